// ===== rtl/core/gdq_pkg.sv =====
// Shared types, constants and fp conversion functions for the weight dequantizer.
package gdq_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned RegW  = 13;
  localparam int unsigned IdxW  = 38;
  localparam int unsigned TileRows = 4;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_LAYOUT  = 3'd1,
    REG_PADDED  = 3'd2,
    REG_KEPT    = 3'd3,
    REG_RLEN    = 3'd4,
    REG_GSL     = 3'd5,
    REG_GCNT    = 3'd6
  } reg_idx_e;

  localparam logic OP_SCALE = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic        inter;
    logic [12:0] padded;
    logic [12:0] kept;
    logic [12:0] rlen;
    logic [3:0]  gsl;
    logic [12:0] gcnt;
  } cfg_t;

  typedef struct packed {
    logic [23:0] prow;
    logic [12:0] pcol;
    logic [19:0] ibn;
    logic [1:0]  ir;
    logic [12:0] ibk;
    logic [1:0]  ic;
    logic [21:0] sbn;
    logic [1:0]  sr;
    logic [12:0] sgrp;
    logic [23:0] spos;
    logic [23:0] dpos;
  } pos_t;

  function automatic logic [12:0] nz13(logic [12:0] v);
    return (v == 13'd0) ? 13'd1 : v;
  endfunction

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [19:0] sh;
    logic [7:0]  ex;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    sh = {m, 10'd0} >> p;
    ex = 8'd103 + {4'd0, p};
    if (e == 5'd0) begin
      if (m == 10'd0) return {h[15], 31'd0};
      return {h[15], ex, sh[9:0], 13'd0};
    end
    if (e == 5'h1F) return {h[15], 8'hFF, m, 13'd0};
    return {h[15], 8'd112 + {3'd0, e}, m, 13'd0};
  endfunction

  function automatic logic [31:0] scaled_product(logic [15:0] s, logic [7:0] q);
    logic        neg;
    logic [8:0]  mag;
    logic        sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [10:0] big;
    logic [18:0] p;
    logic [4:0]  h;
    logic [41:0] sh;
    logic [7:0]  ex;
    neg = q[7];
    mag = neg ? (9'd256 - {1'b0, q}) : {1'b0, q};
    sgn = s[15] ^ neg;
    e   = s[14:10];
    m   = s[9:0];
    big = (e == 5'd0) ? {1'b0, m} : {1'b1, m};
    p   = 19'(mag[7:0] * big);
    h   = 5'd0;
    for (int i = 0; i < 19; i++) begin
      if (p[i]) h = 5'(i);
    end
    sh = {p, 23'd0} >> h;
    ex = (e == 5'd0) ? (8'd103 + {3'd0, h}) : (8'd102 + {3'd0, h} + {3'd0, e});
    if (e == 5'h1F) begin
      if (m != 10'd0) return half_to_single(s) | 32'h0040_0000;
      if (mag == 9'd0) return 32'h7FC0_0000;
      return {sgn, 31'h7F80_0000};
    end
    if (p == 19'd0) return {sgn, 31'd0};
    return {sgn, ex, sh[22:0]};
  endfunction

endpackage

// ===== rtl/core/grouped_int8_weight_dequantizer_unit.sv =====
// Top level of the grouped int8 weight dequantizer.
// Slave stream: one beat per item. tuser = op (0 scale, 1 data), tdata = 16-bit value.
// Scale beats are written to the scale store and give no output beat. Data beats
// give at most one output beat: tdata = {result_bits, col_index, row_index}.
// In int8 mode rows at or beyond kept_rows, padded rows and columns past the row are
// dropped; in fp16 mode every data beat gives one output.
// An input beat first registers the scale store read and address multiply, then the
// product and fp32 packing in the output register.
// Throughput is one beat per cycle while no rebuild runs, set by the single-port scale store.
// A stalled master stalls both stages and drops tready on the slave side.
// Config writes go through the plain write port; the user must write only while the
// block is idle, the block itself does not enforce it. After each write the running
// positions are rebuilt by serial dividers; tready stays low until they are loaded.
// Reset clears the positions and loads the register defaults; the scale store is
// not cleared and must be written before use.
module grouped_int8_weight_dequantizer_unit import gdq_pkg::*; #(
  parameter int unsigned SCALE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [11:0] row_index, [23:12] col_index, [55:24] result_bits
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(SCALE_DEPTH);
  localparam logic [IdxW-1:0] DepthW = IdxW'(SCALE_DEPTH);

  cfg_t cfg_q;
  pos_t pos;
  logic busy;

  logic [15:0] mem [SCALE_DEPTH];
  logic [15:0] rdata_q;

  logic        en, acc, acc_d, acc_s;
  logic [12:0] g;
  logic [23:0] row;
  logic [14:0] col, grp;
  logic        keep, gz;
  logic [23:0] mul_a;
  logic [36:0] prod;
  logic [IdxW-1:0] idx, dest;

  logic        s1_valid_q, s1_mode_q, s1_zero_q, s1_oob_q;
  logic [15:0] s1_val_q;
  logic [11:0] s1_row_q, s1_col_q;
  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic [31:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 1'b0;
      cfg_q.inter  <= 1'b0;
      cfg_q.padded <= 13'd4;
      cfg_q.kept   <= 13'd1;
      cfg_q.rlen   <= 13'd4;
      cfg_q.gsl    <= 4'd5;
      cfg_q.gcnt   <= 13'd1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:   cfg_q.mode   <= cfg_wdata_i[0];
        REG_LAYOUT: cfg_q.inter  <= cfg_wdata_i[0];
        REG_PADDED: cfg_q.padded <= cfg_wdata_i;
        REG_KEPT:   cfg_q.kept   <= cfg_wdata_i;
        REG_RLEN:   cfg_q.rlen   <= cfg_wdata_i;
        REG_GSL:    cfg_q.gsl    <= cfg_wdata_i[3:0];
        REG_GCNT:   cfg_q.gcnt   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en && !busy && !cfg_we_i;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign acc_d         = acc && (s_axis_tuser == OP_DATA);
  assign acc_s         = acc && (s_axis_tuser == OP_SCALE);

  gdq_pos_track u_pos (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cfg_we_i,
    .acc_scale_i(acc_s), .acc_data_i(acc_d), .pos_o(pos), .busy_o(busy)
  );

  assign g = nz13(cfg_q.gcnt);

  always_comb begin
    if (cfg_q.mode || !cfg_q.inter) begin
      row = pos.prow;
      col = {2'b0, pos.pcol};
    end else begin
      row = {2'b0, pos.ibn, pos.ir};
      col = {pos.ibk, pos.ic};
    end
    keep  = cfg_q.mode || (row < {11'd0, cfg_q.kept} && row < {11'd0, cfg_q.padded}
            && col < {2'b0, cfg_q.rlen});
    grp   = col >> cfg_q.gsl;
    gz    = grp >= {2'b0, g};
    mul_a = (s_axis_tuser == OP_DATA) ? row : {pos.sbn, pos.sr};
    prod  = 37'(mul_a * g);
    idx   = {1'b0, prod} + ((s_axis_tuser == OP_DATA) ? IdxW'(grp) : IdxW'(pos.sgrp));
    dest  = cfg_q.inter ? idx : IdxW'(pos.spos);
  end

  always_ff @(posedge clk_i) begin
    if (acc_s && dest < DepthW) mem[dest[AW-1:0]] <= s_axis_tdata;
    if (acc_d) rdata_q <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= acc_d && keep;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (acc_d) begin
        s1_mode_q <= cfg_q.mode;
        s1_zero_q <= gz;
        s1_oob_q  <= idx >= DepthW;
        s1_val_q  <= s_axis_tdata;
        s1_row_q  <= row[11:0];
        s1_col_q  <= col[11:0];
      end
      out_data_q <= {res, s1_col_q, s1_row_q};
    end
  end

  always_comb begin
    if (s1_mode_q) res = half_to_single(s1_val_q);
    else if (s1_zero_q) res = 32'd0;
    else res = scaled_product(s1_oob_q ? 16'd0 : rdata_q, s1_val_q[7:0]);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("input taken while positions rebuild");
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy) else $error("config write did not start rebuild");
  a_scale_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_s |=> !s1_valid_q) else $error("scale beat produced a result");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !en) |=> s1_valid_q) else $error("stage one lost under stall");

endmodule

// ===== rtl/core/gdq_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module gdq_div import gdq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [12:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [23:0] quot_o,
  output logic [12:0] rem_o
);

  logic [23:0] quot_q, quot_d;
  logic [12:0] rem_q, rem_d;
  logic [12:0] div_q, div_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [13:0] sh;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh     = {rem_q, quot_q[23]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = 13'd0;
      div_d  = divisor_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, div_q}) begin
        rem_d  = 13'(sh - {1'b0, div_q});
        quot_d = {quot_q[22:0], 1'b1};
      end else begin
        rem_d  = sh[12:0];
        quot_d = {quot_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/gdq_pos_track.sv =====
// Running scale and data positions kept as row/column counters, rebuilt after config writes.
module gdq_pos_track import gdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cfg_we_i,
  input  logic acc_scale_i,
  input  logic acc_data_i,
  output pos_t pos_o,
  output logic busy_o
);

  pos_t        pos_q, pos_d;
  logic        pend_q;
  logic [12:0] g, klen, kq;
  logic        bz [3];
  logic        dn [3];
  logic [23:0] quo [3];
  logic [12:0] rmd [3];

  assign g    = nz13(cfg_i.gcnt);
  assign klen = nz13(cfg_i.rlen);
  assign kq   = nz13({2'b0, cfg_i.rlen[12:2]});

  gdq_div u_div_plain (
    .clk_i, .rst_ni, .start_i(pend_q), .dividend_i(pos_q.dpos), .divisor_i(klen),
    .busy_o(bz[0]), .done_o(dn[0]), .quot_o(quo[0]), .rem_o(rmd[0])
  );
  gdq_div u_div_tile (
    .clk_i, .rst_ni, .start_i(pend_q), .dividend_i({4'd0, pos_q.dpos[23:4]}), .divisor_i(kq),
    .busy_o(bz[1]), .done_o(dn[1]), .quot_o(quo[1]), .rem_o(rmd[1])
  );
  gdq_div u_div_scale (
    .clk_i, .rst_ni, .start_i(pend_q), .dividend_i({2'd0, pos_q.spos[23:2]}), .divisor_i(g),
    .busy_o(bz[2]), .done_o(dn[2]), .quot_o(quo[2]), .rem_o(rmd[2])
  );

  always_comb begin
    pos_d = pos_q;
    if (acc_data_i) begin
      pos_d.dpos = pos_q.dpos + 24'd1;
      if ({1'b0, pos_q.pcol} + 14'd1 >= {1'b0, klen}) begin
        pos_d.pcol = 13'd0;
        pos_d.prow = pos_q.prow + 24'd1;
      end else begin
        pos_d.pcol = pos_q.pcol + 13'd1;
      end
      pos_d.ic = pos_q.ic + 2'd1;
      if (pos_q.ic == 2'd3) begin
        pos_d.ir = pos_q.ir + 2'd1;
        if (pos_q.ir == 2'd3) begin
          if ({1'b0, pos_q.ibk} + 14'd1 >= {1'b0, kq}) begin
            pos_d.ibk = 13'd0;
            pos_d.ibn = pos_q.ibn + 20'd1;
          end else begin
            pos_d.ibk = pos_q.ibk + 13'd1;
          end
        end
      end
      if (pos_q.dpos == 24'hFF_FFFF) begin
        pos_d.dpos = '0; pos_d.prow = '0; pos_d.pcol = '0;
        pos_d.ibn = '0; pos_d.ir = '0; pos_d.ibk = '0; pos_d.ic = '0;
      end
    end
    if (acc_scale_i) begin
      pos_d.spos = pos_q.spos + 24'd1;
      pos_d.sr   = pos_q.sr + 2'd1;
      if (pos_q.sr == 2'd3) begin
        if ({1'b0, pos_q.sgrp} + 14'd1 >= {1'b0, g}) begin
          pos_d.sgrp = 13'd0;
          pos_d.sbn  = pos_q.sbn + 22'd1;
        end else begin
          pos_d.sgrp = pos_q.sgrp + 13'd1;
        end
      end
      if (pos_q.spos == 24'hFF_FFFF) begin
        pos_d.spos = '0; pos_d.sr = '0; pos_d.sgrp = '0; pos_d.sbn = '0;
      end
    end
    if (dn[0]) begin
      pos_d.prow = quo[0];
      pos_d.pcol = rmd[0];
    end
    if (dn[1]) begin
      pos_d.ibn = quo[1][19:0];
      pos_d.ibk = rmd[1];
      pos_d.ir  = pos_q.dpos[3:2];
      pos_d.ic  = pos_q.dpos[1:0];
    end
    if (dn[2]) begin
      pos_d.sbn  = quo[2][21:0];
      pos_d.sgrp = rmd[2];
      pos_d.sr   = pos_q.spos[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      pend_q <= cfg_we_i;
    end
  end

  assign pos_o  = pos_q;
  // the load cycle of the rebuilt counters still blocks new beats
  assign busy_o = pend_q | bz[0] | bz[1] | bz[2] | dn[0] | dn[1] | dn[2];

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the grouped int8 weight dequantizer top level.
`timescale 1ns / 1ps

module tb;
  import gdq_pkg::*;

  typedef struct {
    logic [11:0] row;
    logic [11:0] col;
    logic [31:0] bits;
  } elem_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] value
  logic        s_axis_tuser;   // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // [11:0] row_index, [23:12] col_index, [55:24] result_bits
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [12:0] cfg_wdata_i;

  grouped_int8_weight_dequantizer_unit u_top (.*);

  // shadow of the block
  logic [15:0] scale_mem [4096];
  int unsigned scale_pos, data_pos;
  int unsigned c_mode, c_inter, c_padded, c_kept, c_rlen, c_gsl, c_gcnt;
  elem_t       pending_elems[$];

  int unsigned errors, items_in, elems_seen, settings_used, stall_cnt;
  bit          jitter_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] half_to_fp32(logic [15:0] h);
    logic [31:0] sgn;
    int          ex;
    logic [10:0] man;
    sgn = {h[15], 31'd0};
    man = {1'b0, h[9:0]};
    if (h[14:10] == 5'd0) begin
      if (man == 11'd0) return sgn;
      ex = 1;
      while (!man[10]) begin
        man = man << 1;
        ex--;
      end
      return sgn | (32'(ex + 112) << 23) | {9'd0, man[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return sgn | 32'h7F80_0000 | {9'd0, man[9:0], 13'd0};
    return sgn | (32'(h[14:10] + 112) << 23) | {9'd0, man[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] weight_times_scale(logic [15:0] s, logic [7:0] q);
    logic [31:0] mag, sig, prod, sgn;
    int          k, hb;
    mag = q[7] ? 32'(256 - q) : 32'(q);
    sgn = {s[15] ^ q[7], 31'd0};
    if (s[14:10] == 5'h1F) begin
      if (s[9:0] != 10'd0) return half_to_fp32(s) | 32'h0040_0000;
      if (mag == 0) return 32'h7FC0_0000;
      return sgn | 32'h7F80_0000;
    end
    if (s[14:10] == 5'd0) begin
      sig = {22'd0, s[9:0]};
      k = -24;
    end else begin
      sig = {21'd0, 1'b1, s[9:0]};
      k = int'(s[14:10]) - 25;
    end
    prod = mag * sig;
    if (prod == 0) return sgn;
    hb = 0;
    while (hb < 31 && (prod >> (hb + 1)) != 0) hb++;
    return sgn | (32'(hb + k + 127) << 23) | ((prod << (23 - hb)) & 32'h007F_FFFF);
  endfunction

  task automatic model_item(input logic op, input logic [15:0] v);
    int unsigned g, klen, kq, pos, row, col, grp;
    longint unsigned idx;
    elem_t e;
    g = (c_gcnt != 0) ? c_gcnt : 1;
    klen = (c_rlen != 0) ? c_rlen : 1;
    if (op == OP_SCALE) begin
      pos = scale_pos;
      if (c_inter != 0)
        idx = (longint'(pos / (TileRows * g)) * TileRows + pos % TileRows) * g
              + (pos / TileRows) % g;
      else
        idx = pos;
      if (idx < 4096) scale_mem[idx] = v;
      scale_pos = (pos + 1) & 24'hFF_FFFF;
      return;
    end
    pos = data_pos;
    data_pos = (pos + 1) & 24'hFF_FFFF;
    if (c_mode != 0) begin
      row = pos / klen;
      col = pos % klen;
      e.bits = half_to_fp32(v);
    end else begin
      if (c_inter != 0) begin
        kq = ((c_rlen >> 2) != 0) ? (c_rlen >> 2) : 1;
        row = (pos / (16 * kq)) * 4 + (pos >> 2) % 4;
        col = ((pos / 16) % kq) * 4 + (pos & 3);
      end else begin
        row = pos / klen;
        col = pos % klen;
      end
      if (row >= c_kept || row >= c_padded || col >= c_rlen) return;
      grp = col >> c_gsl;
      if (grp >= g) begin
        e.bits = 32'd0;
      end else begin
        idx = longint'(row) * g + grp;
        e.bits = weight_times_scale((idx < 4096) ? scale_mem[idx] : 16'd0, v[7:0]);
      end
    end
    e.row = row[11:0];
    e.col = col[11:0];
    pending_elems.insert(pending_elems.size(), e);
  endtask

  task automatic send_item(input logic op, input logic [15:0] v);
    if (jitter_on && $urandom_range(99) < 45) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= v;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    items_in++;
    model_item(op, v);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[12:0];
    @(posedge clk_i);
    case (idx)
      REG_MODE:   c_mode   = val & 1;
      REG_LAYOUT: c_inter  = val & 1;
      REG_PADDED: c_padded = val & 13'h1FFF;
      REG_KEPT:   c_kept   = val & 13'h1FFF;
      REG_RLEN:   c_rlen   = val & 13'h1FFF;
      REG_GSL:    c_gsl    = val & 4'hF;
      REG_GCNT:   c_gcnt   = val & 13'h1FFF;
      default: ;
    endcase
  endtask

  task automatic set_cfg(input int unsigned mode, inter, padded, kept, rlen, gsl, gcnt);
    drain();
    write_reg(REG_MODE, mode);
    write_reg(REG_LAYOUT, inter);
    write_reg(REG_PADDED, padded);
    write_reg(REG_KEPT, kept);
    write_reg(REG_RLEN, rlen);
    write_reg(REG_GSL, gsl);
    write_reg(REG_GCNT, gcnt);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // the low 256 store entries get written here; later run phases write further
  // scale entries. Special fp16 scales sit at the front
  task automatic test_scale_fill();
    logic [15:0] specials [16] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                   16'h7C01, 16'hFE01, 16'h0001, 16'h03FF, 16'h8200,
                                   16'h0400, 16'h7BFF, 16'h3C00, 16'hBC00, 16'h3555,
                                   16'hC000};
    for (int i = 0; i < 256; i++)
      send_item(OP_SCALE, (i < 16) ? specials[i] : 16'($urandom));
  endtask

  task automatic test_directed();
    logic [7:0]  wq [16] = '{8'h7F, 8'h80, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h80,
                             8'h7F, 8'h81, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'h5A, 8'h01};
    logic [15:0] hv [9] = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0400,
                            16'h7BFF, 16'hFC00, 16'h7E00, 16'h7C01};
    // one scale group per column, so data items walk the special scales in order
    set_cfg(0, 0, 4096, 4096, 4, 0, 4);
    for (int i = 0; i < 16; i++) send_item(OP_DATA, {8'($urandom), wq[i]});
    set_cfg(1, 0, 4, 1, 4096, 5, 1);
    for (int i = 0; i < 9; i++) send_item(OP_DATA, hv[i]);
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++)
      send_item(($urandom_range(99) < 85) ? OP_DATA : OP_SCALE, 16'($urandom));
  endtask

  task automatic test_random_settings();
    set_cfg(0, 0, 4096, 512, 16, 2, 4);      run_phase(90);
    set_cfg(0, 1, 4096, 300, 8, 1, 4);       run_phase(90);
    set_cfg(0, 0, 4096, 4096, 1, 0, 4096);   run_phase(80);   // reads past the store
    set_cfg(0, 0, 1, 1, 4096, 12, 1);        run_phase(80);
    set_cfg(1, 0, 4096, 1, 4096, 0, 1);      run_phase(80);
    set_cfg(1, 1, 1, 1, 0, 0, 0);            run_phase(50);
    set_cfg(0, 1, 4096, 4096, 2, 0, 1);      run_phase(80);   // narrow tiled rows
    set_cfg(0, 0, 4, 4096, 0, 0, 0);         run_phase(25);
    set_cfg(0, 0, 8, 4096, 1, 0, 1);         run_phase(25);
    set_cfg(0, 0, 4096, 4096, 64, 0, 3);     run_phase(90);   // columns past the groups
  endtask

  task automatic test_no_gaps();
    jitter_on = 1'b0;
    set_cfg(0, 0, 4096, 4096, 128, 5, 4);
    run_phase(150);
    jitter_on = 1'b1;
  endtask

  task automatic report(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !jitter_on || ($urandom_range(99) >= 31);
  end

  always @(negedge clk_i) begin
    elem_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      elems_seen++;
      if (pending_elems.size() == 0) begin
        report($sformatf("unexpected beat %h", m_axis_tdata));
      end else begin
        e = pending_elems.pop_front();
        if (m_axis_tdata[11:0] != e.row)
          report($sformatf("row %0d, want %0d", m_axis_tdata[11:0], e.row));
        if (m_axis_tdata[23:12] != e.col)
          report($sformatf("col %0d, want %0d", m_axis_tdata[23:12], e.col));
        if (m_axis_tdata[55:24] != e.bits)
          report($sformatf("bits %h, want %h (row %0d col %0d)",
                           m_axis_tdata[55:24], e.bits, e.row, e.col));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt > 5000) begin
        $display("tb: stalled, no beat for %0d cycles", stall_cnt);
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'd0;
    s_axis_tuser  <= OP_SCALE;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_MODE;
    cfg_wdata_i   <= 13'd0;
    jitter_on     = 1'b1;
    errors = 0; items_in = 0; elems_seen = 0; settings_used = 0; stall_cnt = 0;
    scale_pos = 0; data_pos = 0;
    c_mode = 0; c_inter = 0; c_padded = 4; c_kept = 1; c_rlen = 4; c_gsl = 5; c_gcnt = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_scale_fill();
    test_directed();
    test_random_settings();
    test_no_gaps();
    drain();
    $display("tb: %0d beats sent (scale fill included), %0d results checked", items_in,
             elems_seen);
    $display("tb: %0d register settings, int8 and fp16, plain and tiled", settings_used);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
